// ===== rtl/core/fdlm_pkg.sv =====
// ============================================================================
// fdlm_pkg
// Shared widths, constants, register codes and types of the fractional delay
// line with interpolation, smoothing and dry/wet mix.
// ============================================================================
package fdlm_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int DELAY_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int DELAY_W     = 10;
    localparam int FRAC_W      = 16;
    localparam int COEF_W      = 17;

    localparam int SMAX = 8388607;
    localparam int SMIN = -8388608;

    localparam logic [COEF_W-1:0] ONE_Q16  = COEF_W'(65536);
    localparam logic [COEF_W-1:0] COEF_NEW = COEF_W'(45875);
    localparam logic [COEF_W-1:0] COEF_OLD = COEF_W'(19661);

    // multiply-accumulate digit serial geometry
    localparam int DIGIT_W = 3;
    localparam int DIGITS  = 6;
    localparam int LO_W    = DIGITS * DIGIT_W;
    localparam int HI_W    = 29;
    localparam int CNT_W   = $clog2(DIGITS);
    localparam int PROD_W  = SAMPLE_W + DIGIT_W + 1;
    localparam int RND_W   = HI_W + LO_W - FRAC_W;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_WHOLE    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_FRACTION = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_GAIN      = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_MIX_AMOUNT     = CFG_INDEX_W'(3);

    localparam logic [DELAY_W-1:0] RST_DELAY_WHOLE    = DELAY_W'(1023);
    localparam logic [FRAC_W-1:0]  RST_DELAY_FRACTION = FRAC_W'(0);
    localparam logic [COEF_W-1:0]  RST_TONE_GAIN      = COEF_W'(41090);
    localparam logic [COEF_W-1:0]  RST_MIX_AMOUNT     = COEF_W'(32768);

    // one request to the shared unit: round(a*b + c*e), saturated
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a;
        logic        [COEF_W-1:0]   b;
        logic signed [SAMPLE_W-1:0] c;
        logic        [COEF_W-1:0]   e;
    } mac_op_t;

endpackage

// ===== rtl/core/fractional_delay_line_mix.sv =====
// ============================================================================
// fractional_delay_line_mix
// Fractional delay line with linear interpolation, one-pole smoother, tone
// gain and dry/wet mix.
// ============================================================================
// usage
//   s_ channel: one signed 24-bit sample per transaction; m_ channel: one
//   mixed, saturated sample per accepted input, in order.
//   cfg channel: cfg_index 0 delay_whole, 1 delay_fraction, 2 tone_gain,
//   3 mix_amount; other indexes are dropped. cfg_ready is always high; write
//   only while the block is idle.
//   the next sample is taken only after the previous one is done: two delay
//   memory reads, then four passes of the shared multiply-accumulate unit,
//   each over six 3-bit digits.
//   s_ready is high only while no sample is in flight; a finished sample sits
//   in the output register, so the next input is taken while the receiver
//   stalls. a further result waits until the output register drains.
//   reset: registers return to their defaults, smoother and write pointer
//   clear; delay entries never written since reset read as zero through a
//   fill count, so no clearing pass is needed.
// ============================================================================
module fractional_delay_line_mix (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic signed [fdlm_pkg::SAMPLE_W-1:0]        s_sample_in,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [fdlm_pkg::SAMPLE_W-1:0]        m_sample_out,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [fdlm_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [fdlm_pkg::CFG_DATA_W-1:0]             cfg_data
);
    import fdlm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD1      = 4'd1;
    localparam logic [3:0] S_RD2      = 4'd2;
    localparam logic [3:0] S_INTERP   = 4'd3;
    localparam logic [3:0] S_W_INTERP = 4'd4;
    localparam logic [3:0] S_W_SMOOTH = 4'd5;
    localparam logic [3:0] S_W_WET    = 4'd6;
    localparam logic [3:0] S_W_MIX    = 4'd7;
    localparam logic [3:0] S_HOLD     = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [DELAY_W-1:0] delay_whole_reg;
    logic [FRAC_W-1:0]  delay_fraction_reg;
    logic [COEF_W-1:0]  tone_gain_reg;
    logic [COEF_W-1:0]  mix_amount_reg;

    logic [ADDR_W-1:0]          wp_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic signed [SAMPLE_W-1:0] smoother_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] s1_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_ok_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_out_reg;

    logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];

    logic                       accept;
    logic [ADDR_W-1:0]          d_clamp;
    logic [ADDR_W-1:0]          r1;
    logic [ADDR_W-1:0]          r2;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [SAMPLE_W-1:0] tap;
    logic [COEF_W-1:0]          tg;
    logic [COEF_W-1:0]          mx;
    logic                       out_free;
    logic                       load;

    logic                       mac_start;
    mac_op_t                    mac_op;
    logic                       mac_done;
    logic signed [SAMPLE_W-1:0] mac_result;

    assign s_ready      = (state_reg == S_IDLE);
    assign accept       = s_valid && s_ready;
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

    assign d_clamp = (delay_whole_reg == '0) ? ADDR_W'(1) : ADDR_W'(delay_whole_reg);
    assign r1      = wp_reg - d_clamp;
    assign r2      = r1 - ADDR_W'(1);
    assign rd_addr = (state_reg == S_RD1) ? r1 : r2;
    assign tap     = rd_ok_reg ? rd_data_reg : '0;

    assign tg = (tone_gain_reg > ONE_Q16) ? ONE_Q16 : tone_gain_reg;
    assign mx = (mix_amount_reg > ONE_Q16) ? ONE_Q16 : mix_amount_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = out_free
                      && (((state_reg == S_W_MIX) && mac_done) || (state_reg == S_HOLD));

    always_comb begin
        mac_start = 1'b0;
        mac_op    = '0;
        unique case (state_reg)
            S_INTERP: begin
                mac_start = 1'b1;
                mac_op.a  = s1_reg;
                mac_op.b  = ONE_Q16 - COEF_W'(delay_fraction_reg);
                mac_op.c  = tap;
                mac_op.e  = COEF_W'(delay_fraction_reg);
            end
            S_W_INTERP: begin
                mac_start = mac_done;
                mac_op.a  = mac_result;
                mac_op.b  = COEF_NEW;
                mac_op.c  = smoother_reg;
                mac_op.e  = COEF_OLD;
            end
            S_W_SMOOTH: begin
                mac_start = mac_done;
                mac_op.a  = mac_result;
                mac_op.b  = tg;
            end
            S_W_WET: begin
                mac_start = mac_done;
                mac_op.a  = x_reg;
                mac_op.b  = ONE_Q16 - mx;
                mac_op.c  = mac_result;
                mac_op.e  = mx;
            end
            default: begin
                mac_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (accept) state_next = S_RD1;
            S_RD1:      state_next = S_RD2;
            S_RD2:      state_next = S_INTERP;
            S_INTERP:   state_next = S_W_INTERP;
            S_W_INTERP: if (mac_done) state_next = S_W_SMOOTH;
            S_W_SMOOTH: if (mac_done) state_next = S_W_WET;
            S_W_WET:    if (mac_done) state_next = S_W_MIX;
            S_W_MIX: begin
                if (mac_done) begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            wp_reg             <= '0;
            fill_reg           <= '0;
            smoother_reg       <= '0;
            m_valid_reg        <= 1'b0;
            delay_whole_reg    <= RST_DELAY_WHOLE;
            delay_fraction_reg <= RST_DELAY_FRACTION;
            tone_gain_reg      <= RST_TONE_GAIN;
            mix_amount_reg     <= RST_MIX_AMOUNT;
        end else begin
            state_reg <= state_next;
            if (accept && (fill_reg != FILL_W'(DELAY_DEPTH))) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (state_reg == S_RD2) begin
                wp_reg <= wp_reg + ADDR_W'(1);
            end
            if ((state_reg == S_W_SMOOTH) && mac_done) begin
                smoother_reg <= mac_result;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_DELAY_WHOLE:    delay_whole_reg    <= cfg_data[DELAY_W-1:0];
                    CFG_DELAY_FRACTION: delay_fraction_reg <= cfg_data[FRAC_W-1:0];
                    CFG_TONE_GAIN:      tone_gain_reg      <= cfg_data[COEF_W-1:0];
                    CFG_MIX_AMOUNT:     mix_amount_reg     <= cfg_data[COEF_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // delay memory: write on input transaction, registered read
    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[wp_reg] <= s_sample_in;
        end
        rd_data_reg <= mem[rd_addr];
        rd_ok_reg   <= ({1'b0, rd_addr} < fill_reg);
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= s_sample_in;
        end
        if (state_reg == S_RD2) begin
            s1_reg <= tap;
        end
        if (load) begin
            m_sample_out_reg <= mac_result;
        end
    end

    fdlm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .op      (mac_op),
        .done    (mac_done),
        .result  (mac_result)
    );

endmodule

// ===== rtl/core/fdlm_mac.sv =====
// ============================================================================
// fdlm_mac
// Digit serial dual multiply-accumulate: round(a*b + c*e) to Q16, saturated
// to 24 bits, three coefficient bits per cycle.
// ============================================================================
module fdlm_mac (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  fdlm_pkg::mac_op_t                      op,
    output logic                                   done,
    output logic signed [fdlm_pkg::SAMPLE_W-1:0]   result
);
    import fdlm_pkg::*;

    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] c_reg;
    logic [LO_W-1:0]            b_reg;
    logic [LO_W-1:0]            e_reg;
    logic signed [HI_W-1:0]     hi_reg;
    logic [LO_W-1:0]            lo_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic signed [PROD_W-1:0]   pa;
    logic signed [PROD_W-1:0]   pc;
    logic signed [HI_W-1:0]     hi_sum;
    logic signed [RND_W-1:0]    p_hi;
    logic signed [RND_W-1:0]    rounded;

    assign pa     = a_reg * $signed({1'b0, b_reg[DIGIT_W-1:0]});
    assign pc     = c_reg * $signed({1'b0, e_reg[DIGIT_W-1:0]});
    assign hi_sum = hi_reg + HI_W'(pa) + HI_W'(pc);

    // round to nearest, ties up: drop FRAC_W bits and add the next lower bit
    assign p_hi    = $signed({hi_reg, lo_reg[LO_W-1:FRAC_W]});
    assign rounded = p_hi + $signed({{(RND_W-1){1'b0}}, lo_reg[FRAC_W-1]});

    always_comb begin
        if (rounded > SMAX) begin
            result = SAMPLE_W'(SMAX);
        end else if (rounded < SMIN) begin
            result = SAMPLE_W'(SMIN);
        end else begin
            result = rounded[SAMPLE_W-1:0];
        end
    end

    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIGITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= op.a;
            c_reg  <= op.c;
            b_reg  <= LO_W'(op.b);
            e_reg  <= LO_W'(op.e);
            hi_reg <= '0;
            lo_reg <= '0;
        end else if (busy_reg) begin
            hi_reg <= hi_sum >>> DIGIT_W;
            lo_reg <= {hi_sum[DIGIT_W-1:0], lo_reg[LO_W-1:DIGIT_W]};
            b_reg  <= b_reg >> DIGIT_W;
            e_reg  <= e_reg >> DIGIT_W;
        end
    end

endmodule

// ===== rtl/core/fdlm_checker.sv =====
// ============================================================================
// fdlm_checker
// Port level checks of the fractional delay line mix, bound to the top level.
// ============================================================================
module fdlm_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic signed [fdlm_pkg::SAMPLE_W-1:0]  s_sample_in,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [fdlm_pkg::SAMPLE_W-1:0]  m_sample_out,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [fdlm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input logic [fdlm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fdlm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out))
        else $error("result changed while stalled");

    // one sample in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a sample is in flight");

    // a new result only appears as the block goes idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while still busy");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state after reset wrong");

endmodule

bind fractional_delay_line_mix fdlm_checker u_checker (.*);
